/* sv/rgos_pkg.sv */
// Shared types, fixed-point constants and CORDIC tables for the goal and
// obstacle steering pipeline. No dependencies.
package rgos_pkg;

  // Word widths along the datapath
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned MAX_SENSORS  = 8;
  localparam int unsigned ANG_W        = 20;  // Q.16 angle, up to 1.5 pi
  localparam int unsigned MAG_W        = 17;  // clipped norm, 0..1.0 in Q.16
  localparam int unsigned HEAD_W       = 20;  // heading scaled to Q.16
  localparam int unsigned DXY_W        = 23;  // goal offset scaled to Q.16
  localparam int unsigned OBS_W        = 22;  // obstacle term after /1000
  localparam int unsigned U_W          = 22;  // command vector
  localparam int unsigned SPD_W        = 5;

  // Q.16 constants
  localparam int Q_PI      = 205887;
  localparam int Q_HALF_PI = 102944;
  localparam int Q_TWO_PI  = 411775;
  localparam int Q_ONE     = 65536;
  localparam int KINV      = 39797;
  localparam int SPEED_K   = 411566;
  localparam int SPD_MAX   = 12;

  // floor(n/125) = (n * DIV125_M) >> DIV125_SH for n < 2^28
  localparam int DIV125_M  = 274877907;
  localparam int DIV125_SH = 35;
  // floor(n * 2^16 / Q_PI) = (n * HPI_M) >> 37 for n < 2^19
  localparam logic [35:0] HPI_M = 36'd43748266063;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GOAL_X  = 2'd0,
    REG_GOAL_Y  = 2'd1,
    REG_DET_THR = 2'd2
  } cfg_reg_e;

  // Front-end result handed to the first vectoring unit
  typedef struct packed {
    logic signed [DXY_W-1:0]  dx;
    logic signed [DXY_W-1:0]  dy;
    logic signed [HEAD_W-1:0] head;
    logic signed [OBS_W-1:0]  qx;
    logic signed [OBS_W-1:0]  qy;
  } front_out_t;

  // Items carried alongside the first vectoring unit
  typedef struct packed {
    logic signed [HEAD_W-1:0] head;
    logic signed [OBS_W-1:0]  qx;
    logic signed [OBS_W-1:0]  qy;
  } vec1_sb_t;

  // arctan(2^-i) in Q.16
  function automatic logic signed [ANG_W-1:0] atan_c(int unsigned i);
    case (i)
      0:       return ANG_W'(51472);
      1:       return ANG_W'(30385);
      2:       return ANG_W'(16055);
      3:       return ANG_W'(8150);
      4:       return ANG_W'(4091);
      5:       return ANG_W'(2047);
      6:       return ANG_W'(1024);
      7:       return ANG_W'(512);
      8:       return ANG_W'(256);
      9:       return ANG_W'(128);
      10:      return ANG_W'(64);
      11:      return ANG_W'(32);
      12:      return ANG_W'(16);
      13:      return ANG_W'(8);
      14:      return ANG_W'(4);
      15:      return ANG_W'(2);
      default: return '0;
    endcase
  endfunction

  // Sensor direction vectors, Q.16
  function automatic logic signed [17:0] dir_x_c(int unsigned i);
    case (i)
      0:       return 18'sd16961;
      1:       return 18'sd46341;
      2:       return 18'sd65536;
      3:       return 18'sd37591;
      4:       return -18'sd37591;
      5:       return -18'sd65536;
      6:       return -18'sd46341;
      7:       return -18'sd16961;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [17:0] dir_y_c(int unsigned i);
    case (i)
      0:       return 18'sd63301;
      1:       return 18'sd46341;
      2:       return 18'sd0;
      3:       return -18'sd53687;
      4:       return -18'sd53687;
      5:       return 18'sd0;
      6:       return 18'sd46341;
      7:       return 18'sd63301;
      default: return '0;
    endcase
  endfunction

endpackage

/* sv/rgos_in_if.sv */
// Request channel: robot pose and proximity readings.
// Stand-alone interface, no dependencies.
interface rgos_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;
  logic [11:0]        prox_0;
  logic [11:0]        prox_1;
  logic [11:0]        prox_2;
  logic [11:0]        prox_3;
  logic [11:0]        prox_4;
  logic [11:0]        prox_5;
  logic [11:0]        prox_6;
  logic [11:0]        prox_7;

  modport source (
    output valid, pose_x, pose_y, pose_heading,
    output prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
    input  ready
  );
  modport sink (
    input  valid, pose_x, pose_y, pose_heading,
    input  prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
    output ready
  );
endinterface

/* sv/rgos_out_if.sv */
// Result channel: left and right wheel speed commands.
// Stand-alone interface, no dependencies.
interface rgos_out_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] left_speed;
  logic signed [4:0] right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink (input valid, left_speed, right_speed, output ready);
endinterface

/* sv/rgos_cfg_if.sv */
// Configuration write channel: register index and write data.
// Stand-alone interface, no dependencies.
interface rgos_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/rgos_front.sv */
// Front end: goal offset, heading scaling and the obstacle repulsion term.
// Five register stages; uses rgos_pkg.
module rgos_front import rgos_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [15:0]                pose_x_i,
  input  logic signed [15:0]                pose_y_i,
  input  logic signed [15:0]                pose_heading_i,
  input  logic [MAX_SENSORS-1:0][11:0]      prox_i,
  input  logic signed [15:0]                goal_x_i,
  input  logic signed [15:0]                goal_y_i,
  input  logic [11:0]                       det_thr_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output front_out_t                        data_o
);

  localparam int unsigned NST = 5;

  typedef struct packed {
    logic signed [DXY_W-1:0]  dx;
    logic signed [DXY_W-1:0]  dy;
    logic signed [HEAD_W-1:0] head;
  } base_t;

  // Stage handshake: a stage loads when it is empty or its successor moves
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  // Stage 0: offsets, scaling and per-sensor products
  base_t                    base_d;
  base_t                    base_q [NST];
  logic signed [16:0]       dxd, dyd;
  logic signed [30:0]       lx_d [MAX_SENSORS];
  logic signed [30:0]       ly_d [MAX_SENSORS];
  logic signed [30:0]       lx_q [MAX_SENSORS];
  logic signed [30:0]       ly_q [MAX_SENSORS];
  logic                     sense_d;
  logic [1:0]               sense_q;

  always_comb begin
    dxd = {goal_x_i[15], goal_x_i} - {pose_x_i[15], pose_x_i};
    dyd = {goal_y_i[15], goal_y_i} - {pose_y_i[15], pose_y_i};
    base_d.dx   = {dxd, 6'b0};
    base_d.dy   = {dyd, 6'b0};
    base_d.head = {pose_heading_i, 4'b0};
    sense_d = 1'b0;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      lx_d[i] = '0;
      ly_d[i] = '0;
      if (i < NUM_SENSORS) begin
        lx_d[i] = $signed({1'b0, prox_i[i]}) * dir_x_c(i);
        ly_d[i] = $signed({1'b0, prox_i[i]}) * dir_y_c(i);
        if (prox_i[i] > det_thr_i) sense_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      base_q[0]  <= base_d;
      lx_q       <= lx_d;
      ly_q       <= ly_d;
      sense_q[0] <= sense_d;
    end
  end

  // Stage 1: two four-term partial sums per axis
  logic signed [30:0] sxa_q, sxb_q, sya_q, syb_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      base_q[1]  <= base_q[0];
      sense_q[1] <= sense_q[0];
      sxa_q <= lx_q[0] + lx_q[1] + lx_q[2] + lx_q[3];
      sxb_q <= lx_q[4] + lx_q[5] + lx_q[6] + lx_q[7];
      sya_q <= ly_q[0] + ly_q[1] + ly_q[2] + ly_q[3];
      syb_q <= ly_q[4] + ly_q[5] + ly_q[6] + ly_q[7];
    end
  end

  // Stage 2: total, gate on detection, magnitude divided by 8
  logic signed [31:0] tx, ty;
  logic [31:0]        mx, my;
  logic [27:0]        m8x_q, m8y_q;
  logic [1:0]         negx_q, negy_q;

  always_comb begin
    tx = 32'(sxa_q) + 32'(sxb_q);
    ty = 32'(sya_q) + 32'(syb_q);
    if (!sense_q[1]) begin
      tx = '0;
      ty = '0;
    end
    mx = tx[31] ? 32'(-tx) : 32'(tx);
    my = ty[31] ? 32'(-ty) : 32'(ty);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      base_q[2] <= base_q[1];
      m8x_q     <= mx[30:3];
      m8y_q     <= my[30:3];
      negx_q[0] <= tx[31];
      negy_q[0] <= ty[31];
    end
  end

  // Stage 3: divide by 125 through the reciprocal
  logic [56:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      base_q[3] <= base_q[2];
      px_q      <= m8x_q * 29'(DIV125_M);
      py_q      <= m8y_q * 29'(DIV125_M);
      negx_q[1] <= negx_q[0];
      negy_q[1] <= negy_q[0];
    end
  end

  // Stage 4: quotient with the sign put back (truncates toward zero)
  logic signed [OBS_W-1:0] qx_d, qy_d, qx_q, qy_q;

  always_comb begin
    qx_d = $signed({1'b0, px_q[DIV125_SH+20:DIV125_SH]});
    qy_d = $signed({1'b0, py_q[DIV125_SH+20:DIV125_SH]});
    if (negx_q[1]) qx_d = -qx_d;
    if (negy_q[1]) qy_d = -qy_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      base_q[4] <= base_q[3];
      qx_q      <= qx_d;
      qy_q      <= qy_d;
    end
  end

  assign data_o.dx   = base_q[4].dx;
  assign data_o.dy   = base_q[4].dy;
  assign data_o.head = base_q[4].head;
  assign data_o.qx   = qx_q;
  assign data_o.qy   = qy_q;

endmodule

/* sv/rgos_vec.sv */
// Pipelined vectoring CORDIC: clipped, gain-corrected norm and angle of (x,y).
// One stage per iteration plus pre-rotation and gain stages; uses rgos_pkg.
module rgos_vec import rgos_pkg::*; #(
  parameter int unsigned IN_W = 23,
  parameter int unsigned SB_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [IN_W-1:0]  x_i,
  input  logic signed [IN_W-1:0]  y_i,
  input  logic [SB_W-1:0]         sb_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [MAG_W-1:0]        mag_o,
  output logic signed [ANG_W-1:0] ang_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int unsigned CW  = IN_W + 2;
  localparam int unsigned NST = CORDIC_STEPS + 3;
  localparam int unsigned SMUL = CORDIC_STEPS + 1;

  // Stage handshake
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  logic signed [CW-1:0]    x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0]    y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];
  logic                    zero_q [NST];
  logic [SB_W-1:0]         sb_q [NST];

  // Sideband and zero flag travel with each stage
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sb_q[0]   <= sb_i;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        sb_q[k]   <= sb_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // Stage 0: fold the left half-plane onto the right
  logic signed [CW-1:0]    xe, ye, x0, y0;
  logic signed [ANG_W-1:0] z0;

  always_comb begin
    xe = {{2{x_i[IN_W-1]}}, x_i};
    ye = {{2{y_i[IN_W-1]}}, y_i};
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe[CW-1]) begin
      x0 = -xe;
      y0 = -ye;
      z0 = ye[CW-1] ? -ANG_W'(Q_PI) : ANG_W'(Q_PI);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= z0;
    end
  end

  // Iterations: drive y toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (rdy[i+1]) begin
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_c(i);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_c(i);
        end
      end
    end
  end

  // Gain correction multiply
  logic signed [CW+16:0]   prod_q;
  logic signed [ANG_W-1:0] zm_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SMUL]) begin
      prod_q <= x_q[CORDIC_STEPS] * $signed({1'b0, 16'(KINV)});
      zm_q   <= z_q[CORDIC_STEPS];
    end
  end

  // Shift, clip at one, zero-vector override
  logic signed [CW:0]      m;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic signed [ANG_W-1:0] ang_d, ang_q;

  always_comb begin
    m     = $signed(prod_q[CW+16:16]);
    mag_d = m[MAG_W-1:0];
    if (m > $signed((CW+1)'(Q_ONE))) mag_d = MAG_W'(Q_ONE);
    ang_d = zm_q;
    if (zero_q[SMUL]) begin
      mag_d = '0;
      ang_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      mag_q <= mag_d;
      ang_q <= ang_d;
    end
  end

  assign mag_o = mag_q;
  assign ang_o = ang_q;
  assign sb_o  = sb_q[NST-1];

endmodule

/* sv/rgos_rot.sv */
// Pipelined rotation CORDIC: goal vector in the robot frame, minus the
// obstacle term. Gain, wrap/fold, sixteen iterations, subtract; uses rgos_pkg.
module rgos_rot import rgos_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [MAG_W-1:0]         dist_i,
  input  logic signed [ANG_W-1:0]  bear_i,
  input  logic signed [HEAD_W-1:0] head_i,
  input  logic signed [OBS_W-1:0]  qx_i,
  input  logic signed [OBS_W-1:0]  qy_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [U_W-1:0]    ux_o,
  output logic signed [U_W-1:0]    uy_o
);

  localparam int unsigned NST  = CORDIC_STEPS + 3;
  localparam int unsigned RW   = 19;
  localparam int unsigned AW0  = 22;
  localparam int unsigned SOUT = NST - 1;

  // Stage handshake
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  // Obstacle term rides along until the final subtract
  logic signed [OBS_W-1:0] qx_q [SOUT];
  logic signed [OBS_W-1:0] qy_q [SOUT];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      qx_q[0] <= qx_i;
      qy_q[0] <= qy_i;
    end
    for (int k = 1; k < SOUT; k++) begin
      if (rdy[k]) begin
        qx_q[k] <= qx_q[k-1];
        qy_q[k] <= qy_q[k-1];
      end
    end
  end

  // Stage 0: gain pre-scale of the norm, relative bearing
  logic [32:0]           gp_q;
  logic signed [AW0-1:0] a0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      gp_q <= dist_i * 16'(KINV);
      a0_q <= AW0'(bear_i) - AW0'(head_i);
    end
  end

  // Stage 1: wrap into [-pi,pi], fold into [-pi/2,pi/2]
  logic signed [AW0-1:0] aw;
  logic signed [RW-1:0]  xr;
  logic signed [RW-1:0]  x_q [CORDIC_STEPS+1];
  logic signed [RW-1:0]  y_q [CORDIC_STEPS+1];
  logic signed [RW-1:0]  a_q [CORDIC_STEPS+1];

  always_comb begin
    aw = a0_q;
    xr = RW'($signed({1'b0, gp_q[32:16]}));
    for (int k = 0; k < 3; k++) begin
      if (aw > AW0'(Q_PI)) aw = aw - AW0'(Q_TWO_PI);
      else if (aw < -AW0'(Q_PI)) aw = aw + AW0'(Q_TWO_PI);
    end
    if (aw > AW0'(Q_HALF_PI)) begin
      aw = aw - AW0'(Q_PI);
      xr = -xr;
    end else if (aw < -AW0'(Q_HALF_PI)) begin
      aw = aw + AW0'(Q_PI);
      xr = -xr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      x_q[0] <= xr;
      y_q[0] <= '0;
      a_q[0] <= aw[RW-1:0];
    end
  end

  // Iterations: drive the residual angle toward zero
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [RW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (rdy[i+2]) begin
        if (!a_q[i][RW-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          a_q[i+1] <= a_q[i] - RW'(atan_c(i));
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          a_q[i+1] <= a_q[i] + RW'(atan_c(i));
        end
      end
    end
  end

  // Final stage: subtract the obstacle term
  logic signed [U_W-1:0] ux_q, uy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SOUT]) begin
      ux_q <= U_W'(x_q[CORDIC_STEPS]) - U_W'(qx_q[SOUT-1]);
      uy_q <= U_W'(y_q[CORDIC_STEPS]) - U_W'(qy_q[SOUT-1]);
    end
  end

  assign ux_o = ux_q;
  assign uy_o = uy_q;

endmodule

/* sv/rgos_wheel.sv */
// Wheel speed stage: bearing over pi, range -/+ that, scaling, clamp.
// Four register stages, the last is the output register; uses rgos_pkg.
module rgos_wheel import rgos_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [MAG_W-1:0]         d_i,
  input  logic signed [ANG_W-1:0]  h_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [SPD_W-1:0]  left_o,
  output logic signed [SPD_W-1:0]  right_o
);

  localparam int unsigned NST = 4;

  // Stage handshake
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NST-1];

  // Stage 0: |h| times 2^16/pi, two partial products
  logic signed [ANG_W-1:0] habs;
  logic [36:0]             ph_q, pl_q;
  logic                    hneg_q;
  logic [MAG_W-1:0]        d_q;

  assign habs = h_i[ANG_W-1] ? -h_i : h_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ph_q   <= habs[18:0] * HPI_M[35:18];
      pl_q   <= habs[18:0] * HPI_M[17:0];
      hneg_q <= h_i[ANG_W-1];
      d_q    <= d_i;
    end
  end

  // Stage 1: combine partials, signed h/pi, both wheel terms
  logic [55:0]        hsum;
  logic signed [18:0] hp;
  logic signed [19:0] wl_d, wr_d, wl_q, wr_q;

  always_comb begin
    hsum = 56'({ph_q, 18'b0}) + 56'(pl_q);
    hp   = $signed({1'b0, hsum[54:37]});
    if (hneg_q) hp = -hp;
    wl_d = $signed({3'b0, d_q}) - 20'(hp);
    wr_d = $signed({3'b0, d_q}) + 20'(hp);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      wl_q <= wl_d;
      wr_q <= wr_d;
    end
  end

  // Stage 2: speed scaling on magnitudes
  logic signed [19:0] wla, wra;
  logic [37:0]        sl_q, sr_q;
  logic               nl_q, nr_q;

  assign wla = wl_q[19] ? -wl_q : wl_q;
  assign wra = wr_q[19] ? -wr_q : wr_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sl_q <= wla[18:0] * 19'(SPEED_K);
      sr_q <= wra[18:0] * 19'(SPEED_K);
      nl_q <= wl_q[19];
      nr_q <= wr_q[19];
    end
  end

  // Stage 3: truncate, clamp, restore sign (output register)
  logic [5:0]             ml, mr;
  logic signed [SPD_W-1:0] left_d, right_d, left_q, right_q;

  always_comb begin
    ml = sl_q[37:32];
    mr = sr_q[37:32];
    if (ml > 6'(SPD_MAX)) ml = 6'(SPD_MAX);
    if (mr > 6'(SPD_MAX)) mr = 6'(SPD_MAX);
    left_d  = $signed(ml[SPD_W-1:0]);
    right_d = $signed(mr[SPD_W-1:0]);
    if (nl_q) left_d = -left_d;
    if (nr_q) right_d = -right_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

/* sv/reactive_goal_and_obstacle_steering.sv */
// Front end, goal vectoring, rotation, command vectoring and wheel stage in
// series; one CORDIC iteration per stage. Throughput: one request per cycle
// while the output is not stalled; every stage holds its own request and
// fills in behind a stalled output. Reset clears all stage valid bits and
// loads the configuration defaults; payload registers are not reset.
module reactive_goal_and_obstacle_steering import rgos_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rgos_in_if.sink   req_i,
  rgos_out_if.source rsp_o,
  rgos_cfg_if.sink  cfg_i
);

  // Configuration registers
  logic signed [15:0] goal_x_q, goal_y_q;
  logic [11:0]        det_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q  <= 16'sd0;
      goal_y_q  <= -16'sd10240;
      det_thr_q <= 12'd300;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_GOAL_X:  goal_x_q  <= cfg_i.data;
        REG_GOAL_Y:  goal_y_q  <= cfg_i.data;
        REG_DET_THR: det_thr_q <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  // Front end
  logic [MAX_SENSORS-1:0][11:0] prox;
  logic                         f_valid, f_ready;
  front_out_t                   f_data;

  assign prox[0] = req_i.prox_0;
  assign prox[1] = req_i.prox_1;
  assign prox[2] = req_i.prox_2;
  assign prox[3] = req_i.prox_3;
  assign prox[4] = req_i.prox_4;
  assign prox[5] = req_i.prox_5;
  assign prox[6] = req_i.prox_6;
  assign prox[7] = req_i.prox_7;

  rgos_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (req_i.valid),
    .ready_o        (req_i.ready),
    .pose_x_i       (req_i.pose_x),
    .pose_y_i       (req_i.pose_y),
    .pose_heading_i (req_i.pose_heading),
    .prox_i         (prox),
    .goal_x_i       (goal_x_q),
    .goal_y_i       (goal_y_q),
    .det_thr_i      (det_thr_q),
    .valid_o        (f_valid),
    .ready_i        (f_ready),
    .data_o         (f_data)
  );

  // Goal range and bearing
  vec1_sb_t                sb1_in, sb1_out;
  logic                    v1_valid, v1_ready;
  logic [MAG_W-1:0]        goal_rng;
  logic signed [ANG_W-1:0] bearing;

  assign sb1_in.head = f_data.head;
  assign sb1_in.qx   = f_data.qx;
  assign sb1_in.qy   = f_data.qy;

  rgos_vec #(
    .IN_W (DXY_W),
    .SB_W ($bits(vec1_sb_t))
  ) u_vec_goal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .x_i     (f_data.dx),
    .y_i     (f_data.dy),
    .sb_i    (sb1_in),
    .valid_o (v1_valid),
    .ready_i (v1_ready),
    .mag_o   (goal_rng),
    .ang_o   (bearing),
    .sb_o    (sb1_out)
  );

  // Robot-frame goal vector minus obstacle term
  logic                  r_valid, r_ready;
  logic signed [U_W-1:0] ux, uy;

  rgos_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_valid),
    .ready_o (v1_ready),
    .dist_i  (goal_rng),
    .bear_i  (bearing),
    .head_i  (sb1_out.head),
    .qx_i    (sb1_out.qx),
    .qy_i    (sb1_out.qy),
    .valid_o (r_valid),
    .ready_i (r_ready),
    .ux_o    (ux),
    .uy_o    (uy)
  );

  // Command range and bearing
  logic                    v2_valid, v2_ready;
  logic [MAG_W-1:0]        cmd_d;
  logic signed [ANG_W-1:0] cmd_h;

  rgos_vec #(
    .IN_W (U_W),
    .SB_W (1)
  ) u_vec_cmd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .ready_o (r_ready),
    .x_i     (ux),
    .y_i     (uy),
    .sb_i    (1'b0),
    .valid_o (v2_valid),
    .ready_i (v2_ready),
    .mag_o   (cmd_d),
    .ang_o   (cmd_h),
    .sb_o    ()
  );

  // Wheel speeds
  rgos_wheel u_wheel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_valid),
    .ready_o (v2_ready),
    .d_i     (cmd_d),
    .h_i     (cmd_h),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .left_o  (rsp_o.left_speed),
    .right_o (rsp_o.right_speed)
  );

`ifndef SYNTHESIS
  // Requests are refused only when the whole pipe is backed up
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_o.valid && !rsp_o.ready))
    else $error("request refused while output not stalled");

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.left_speed <= 5'sd12 && rsp_o.left_speed >= -5'sd12))
    else $error("left speed out of range");

  a_right_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.right_speed <= 5'sd12 && rsp_o.right_speed >= -5'sd12))
    else $error("right speed out of range");
`endif

endmodule

/* test/reactive_goal_and_obstacle_steering_tb.sv */
// Self-checking testbench for reactive_goal_and_obstacle_steering: a directed table,
// then random poses and proximity readings, all checked by a fixed-point steering predictor.
// Depends on rgos_pkg and the rgos_in_if, rgos_out_if and rgos_cfg_if interfaces.
module reactive_goal_and_obstacle_steering_tb;
  import rgos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;  // no register behind this index
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 575;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] hd;
    logic [11:0]        prox [8];
    bit                 known;
    int                 el;
    int                 er;
  } steer_row_t;

  typedef struct {
    logic signed [4:0] left;
    logic signed [4:0] right;
  } speeds_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rgos_in_if  req();
  rgos_out_if rsp();
  rgos_cfg_if cfg();

  reactive_goal_and_obstacle_steering u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of the registers
  logic signed [15:0] goal_x_q = 16'sd0;
  logic signed [15:0] goal_y_q = -16'sd10240;
  logic [11:0]        thr_q = 12'd300;

  speeds_t speeds_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sensed = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint atan_q(int i);
    longint t [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // Vectoring CORDIC: norm and angle in Q.16
  task automatic vect(input longint xi, input longint yi, output longint mag,
                      output longint ang);
    longint x, y, z, xs, ys;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? Q_PI : -Q_PI;
      x = -x; y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_q(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_q(i);
      end
    end
    mag = (x * KINV) >>> 16;
    ang = z;
  endtask

  // Rotation CORDIC of (r, 0) by a
  task automatic rotate(input longint r, input longint ai, output longint ox,
                        output longint oy);
    longint x, y, a, xs, ys;
    x = (r * KINV) >>> 16; y = 0; a = ai;
    for (int i = 0; i < 3; i++) begin
      if (a > Q_PI) a -= Q_TWO_PI;
      else if (a < -Q_PI) a += Q_TWO_PI;
    end
    if (a > Q_HALF_PI) begin
      a -= Q_PI; x = -x;
    end else if (a < -Q_HALF_PI) begin
      a += Q_PI; x = -x;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (a >= 0) begin
        x = x - ys; y = y + xs; a -= atan_q(i);
      end else begin
        x = x + ys; y = y - xs; a += atan_q(i);
      end
    end
    ox = x; oy = y;
  endtask

  function automatic logic signed [4:0] wheel_speed(longint w);
    longint s;
    s = (w * SPEED_K) / (longint'(1) << 32);
    if (s > SPD_MAX) s = SPD_MAX;
    if (s < -SPD_MAX) s = -SPD_MAX;
    return 5'(s);
  endfunction

  // Full steering computation for one request
  task automatic predict_speeds(input steer_row_t r, output speeds_t sp);
    longint dx, dy, head, grange, bear, nx, ny, ax, ay, d, h, hp, p;
    bit sense;
    dx = (longint'(goal_x_q) - longint'(r.px)) * 64;
    dy = (longint'(goal_y_q) - longint'(r.py)) * 64;
    head = longint'(r.hd) * 16;
    vect(dx, dy, grange, bear);
    if (grange > Q_ONE) grange = Q_ONE;
    rotate(grange, bear - head, nx, ny);
    ax = 0; ay = 0; sense = 0;
    for (int i = 0; i < 8; i++) begin
      p = longint'(r.prox[i]);
      if (r.prox[i] > thr_q) sense = 1;
      ax += p * longint'(dir_x_c(i));
      ay += p * longint'(dir_y_c(i));
    end
    if (!sense) begin
      ax = 0; ay = 0;
    end else begin
      n_sensed++;
    end
    vect(nx - ax / 1000, ny - ay / 1000, d, h);
    if (d > Q_ONE) d = Q_ONE;
    hp = (h * Q_ONE) / Q_PI;
    sp.left = wheel_speed(d - hp);
    sp.right = wheel_speed(d + hp);
  endtask

  // Result check against the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (speeds_due.size() == 0) begin
        $error("unexpected result left_speed=%0d right_speed=%0d",
               rsp.left_speed, rsp.right_speed);
        errors++;
      end else begin
        speeds_t e;
        e = speeds_due.pop_front();
        if (rsp.left_speed !== e.left) begin
          $error("left_speed expected %0d actual %0d", e.left, rsp.left_speed);
          errors++;
        end
        if (rsp.right_speed !== e.right) begin
          $error("right_speed expected %0d actual %0d", e.right, rsp.right_speed);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // Receiver side: random stalls plus one long hold-off
  initial rsp.ready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no accepted request, result or write
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one request; leaves valid high for a back-to-back follower
  task automatic send_req(input steer_row_t r);
    speeds_t sp;
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.pose_x <= r.px;
    req.pose_y <= r.py;
    req.pose_heading <= r.hd;
    req.prox_0 <= r.prox[0]; req.prox_1 <= r.prox[1];
    req.prox_2 <= r.prox[2]; req.prox_3 <= r.prox[3];
    req.prox_4 <= r.prox[4]; req.prox_5 <= r.prox[5];
    req.prox_6 <= r.prox[6]; req.prox_7 <= r.prox[7];
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_speeds(r, sp);
    if (r.known && (sp.left != r.el || sp.right != r.er)) begin
      $error("table row: predictor gives %0d/%0d, table %0d/%0d",
             sp.left, sp.right, r.el, r.er);
      errors++;
    end
    if (r.known) begin
      sp.left = 5'(r.el);
      sp.right = 5'(r.er);
    end
    speeds_due.push_back(sp);
    n_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      REG_GOAL_X:  goal_x_q = val;
      REG_GOAL_Y:  goal_y_q = val;
      REG_DET_THR: thr_q = val[11:0];
      default: ;
    endcase
  endtask

  // Quiet the request side and let every result come back
  task automatic drain();
    req.valid <= 1'b0;
    cfg.valid <= 1'b0;
    @(posedge clk_i);
    while (speeds_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic steer_row_t mk(int px, int py, int hd, int p0, int p1, int p2,
                                    int p3, int p4, int p5, int p6, int p7,
                                    bit known = 0, int el = 0, int er = 0);
    steer_row_t r;
    r.px = 16'(px); r.py = 16'(py); r.hd = 16'(hd);
    r.prox = '{12'(p0), 12'(p1), 12'(p2), 12'(p3), 12'(p4), 12'(p5), 12'(p6),
               12'(p7)};
    r.known = known; r.el = el; r.er = er;
    return r;
  endfunction

  function automatic logic [11:0] rand_prox(int mode);
    case (mode)
      0: return 12'($urandom_range(200));
      1: return 12'($urandom_range(4095));
      default: return ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                               : 12'($urandom_range(thr_q));
    endcase
  endfunction

  function automatic steer_row_t rand_row();
    steer_row_t r;
    int mode;
    mode = $urandom_range(2);
    if ($urandom_range(3) == 0) begin
      r.px = 16'($urandom_range(65535));
      r.py = 16'($urandom_range(65535));
    end else begin
      // near the goal, where the obstacle term matters most
      r.px = goal_x_q + 16'($signed($urandom_range(2047)) - 1024);
      r.py = goal_y_q + 16'($signed($urandom_range(2047)) - 1024);
    end
    r.hd = 16'($signed($urandom_range(51472)) - 25736);
    for (int i = 0; i < 8; i++) r.prox[i] = rand_prox(mode);
    r.known = 0; r.el = 0; r.er = 0;
    return r;
  endfunction

  steer_row_t table_rows [$];

  initial begin
    int sidle [3] = '{29, 77, 0};
    int ridle [3] = '{77, 29, 0};
    req.valid = 1'b0;
    req.pose_x = '0; req.pose_y = '0; req.pose_heading = '0;
    req.prox_0 = '0; req.prox_1 = '0; req.prox_2 = '0; req.prox_3 = '0;
    req.prox_4 = '0; req.prox_5 = '0; req.prox_6 = '0; req.prox_7 = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset configuration
    table_rows.push_back(mk(0, -10240, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    table_rows.push_back(mk(0, 0, -6434, 0, 0, 0, 0, 0, 0, 0, 0, 1, 6, 6));
    table_rows.push_back(mk(0, 0, 6434, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(0, 0, 25736, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(0, 0, -25736, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(-32768, -32768, 12868, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(-32768, 32767, -12868, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(0, -10240, 0, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                            4095));
    // reading equal to threshold does not count as a detection
    table_rows.push_back(mk(0, 0, -6434, 300, 300, 300, 300, 300, 300, 300, 300,
                            1, 6, 6));
    for (int s = 0; s < 8; s++) begin
      steer_row_t r;
      r = mk(100, -300, -6434, 0, 0, 0, 0, 0, 0, 0, 0);
      r.prox[s] = 12'd4095;
      table_rows.push_back(r);
    end
    // goal behind the robot: bearing wrap around pi
    table_rows.push_back(mk(0, 0, 6434, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(1, -10240, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(-1, -10240, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (table_rows[k]) send_req(table_rows[k]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      // Register settings for this phase, extremes first
      case (ph)
        0: begin
          cfg_write(REG_UNUSED, 16'hFFFF);
          cfg_write(REG_GOAL_X, 16'h7FFF);
          cfg_write(REG_GOAL_Y, 16'h8000);
          cfg_write(REG_DET_THR, 16'd0);
        end
        1: begin
          cfg_write(REG_GOAL_X, 16'h8000);
          cfg_write(REG_GOAL_Y, 16'h7FFF);
          cfg_write(REG_DET_THR, 16'hFFFF);
        end
        default: begin
          cfg_write(REG_GOAL_X, 16'($urandom_range(65535)));
          cfg_write(REG_GOAL_Y, 16'($urandom_range(65535)));
          cfg_write(REG_DET_THR, 16'd300);
        end
      endcase
      cfg.valid <= 1'b0;
      send_idle = sidle[ph];
      recv_idle = ridle[ph];
      if (ph == 2) hold_req = 400;  // output blocked while requests keep coming
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_req(rand_row());
      drain();
    end

    $display("Sent %0d requests, checked %0d results, %0d with obstacle term active.",
             n_sent, n_checked, n_sensed);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
